>>> sv/plb_pkg.sv
// Shared types and constants for the palette lookup and blend lanes.
package plb_pkg;

    localparam int LANES      = 4;
    localparam int LANE_MAX   = 4;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 2 * PIX_W;
    localparam int MODE_W     = 3;
    localparam int KIND_W     = 2;
    localparam int TAB_DEPTH  = 1 << PIX_W;
    localparam int BLD_DEPTH  = 1 << ADDR_W;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);
    localparam int DLY_STAGES = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL = 2'd0,
        KIND_CMAP  = 2'd1,
        KIND_TRANS = 2'd2,
        KIND_BLEND = 2'd3
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        MODE_COPY   = 3'd0,
        MODE_MAP    = 3'd1,
        MODE_TMAP   = 3'd2,
        MODE_BLEND  = 3'd3,
        MODE_TBLEND = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        PATH_COPY  = 2'd0,
        PATH_MAP   = 2'd1,
        PATH_BLEND = 2'd2
    } t_path;

    typedef logic [LANE_MAX-1:0][PIX_W-1:0] t_pix_vec;

    typedef struct packed {
        logic                vld;
        logic                is_pix;
        logic                wr_trans;
        logic                wr_cmap;
        logic                wr_blend;
        logic                use_trans;
        t_path               path;
        logic [LANE_MAX-1:0] en;
        logic [ADDR_W-1:0]   addr;
        logic [PIX_W-1:0]    data;
    } t_ctl;

    typedef struct packed {
        t_ctl     ctl;
        t_pix_vec src;
        t_pix_vec dst;
    } t_item;

endpackage

>>> sv/plb_front.sv
// Front end: draw mode register and decode of each incoming item.
module plb_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [plb_pkg::MODE_W-1:0] i_cfg_data,
    input  logic [plb_pkg::KIND_W-1:0] i_kind,
    input  plb_pkg::t_pix_vec          i_src,
    input  plb_pkg::t_pix_vec          i_dst,
    input  logic [plb_pkg::LANE_MAX-1:0] i_lane_enable,
    input  logic [plb_pkg::ADDR_W-1:0] i_table_addr,
    input  logic [plb_pkg::PIX_W-1:0]  i_table_data,
    output plb_pkg::t_item             o_item
);

    logic [plb_pkg::MODE_W-1:0] r_draw_mode;
    logic [plb_pkg::MODE_W-1:0] n_draw_mode;
    plb_pkg::t_ctl              ctl;

    always_comb begin
        n_draw_mode = r_draw_mode;
        if (i_cfg_we) begin
            n_draw_mode = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_mode <= plb_pkg::MODE_COPY;
        end else begin
            r_draw_mode <= n_draw_mode;
        end
    end

    always_comb begin
        ctl      = '0;
        ctl.vld  = 1'b1;
        ctl.en   = i_lane_enable;
        ctl.addr = i_table_addr;
        ctl.data = i_table_data;
        ctl.path = plb_pkg::PATH_COPY;
        unique case (plb_pkg::t_kind'(i_kind))
            plb_pkg::KIND_PIXEL: begin
                ctl.is_pix = 1'b1;
                unique case (r_draw_mode)
                    plb_pkg::MODE_MAP: begin
                        ctl.path = plb_pkg::PATH_MAP;
                    end
                    plb_pkg::MODE_TMAP: begin
                        ctl.path      = plb_pkg::PATH_MAP;
                        ctl.use_trans = 1'b1;
                    end
                    plb_pkg::MODE_BLEND: begin
                        ctl.path = plb_pkg::PATH_BLEND;
                    end
                    plb_pkg::MODE_TBLEND: begin
                        ctl.path      = plb_pkg::PATH_BLEND;
                        ctl.use_trans = 1'b1;
                    end
                    // copy, and the unused mode codes
                    default: begin
                        ctl.path = plb_pkg::PATH_COPY;
                    end
                endcase
            end
            plb_pkg::KIND_CMAP: begin
                ctl.wr_cmap = 1'b1;
            end
            plb_pkg::KIND_TRANS: begin
                ctl.wr_trans = 1'b1;
            end
            plb_pkg::KIND_BLEND: begin
                ctl.wr_blend = 1'b1;
            end
        endcase
    end

    assign o_item.ctl = ctl;
    assign o_item.src = i_src;
    assign o_item.dst = i_dst;

endmodule

>>> sv/plb_queue.sv
// Small FIFO that decouples the decode front from the lookup pipeline.
module plb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plb_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_vld,
    output plb_pkg::t_item o_head
);

    plb_pkg::t_item            r_mem [plb_pkg::Q_DEPTH];
    logic [plb_pkg::Q_AW-1:0]  r_wr_ptr;
    logic [plb_pkg::Q_AW-1:0]  r_rd_ptr;
    logic [plb_pkg::Q_CW-1:0]  r_count;
    logic [plb_pkg::Q_AW-1:0]  n_wr_ptr;
    logic [plb_pkg::Q_AW-1:0]  n_rd_ptr;
    logic [plb_pkg::Q_CW-1:0]  n_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_full     = (r_count == plb_pkg::Q_CW'(plb_pkg::Q_DEPTH));
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_head_vld;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> sv/plb_lane.sv
// One lane: private copies of the three tables and the chained lookups.
module plb_lane (
    input  logic                      i_clk,
    input  logic                      i_adv,
    input  plb_pkg::t_ctl             i_ctl0,
    input  plb_pkg::t_ctl             i_ctl1,
    input  plb_pkg::t_ctl             i_ctl2,
    input  plb_pkg::t_ctl             i_ctl3,
    input  logic [plb_pkg::PIX_W-1:0] i_src,
    input  logic [plb_pkg::PIX_W-1:0] i_dst,
    input  logic                      i_en3,
    output logic [plb_pkg::PIX_W-1:0] o_pix
);

    logic [plb_pkg::PIX_W-1:0] r_trans [plb_pkg::TAB_DEPTH];
    logic [plb_pkg::PIX_W-1:0] r_cmap  [plb_pkg::TAB_DEPTH];
    logic [plb_pkg::PIX_W-1:0] r_blend [plb_pkg::BLD_DEPTH];

    logic [plb_pkg::PIX_W-1:0]  r_t1, r_src1, r_dst1;
    logic [plb_pkg::PIX_W-1:0]  r_c2, r_src2, r_dst2;
    logic [plb_pkg::PIX_W-1:0]  r_b3, r_c3, r_src3, r_dst3;
    logic [plb_pkg::PIX_W-1:0]  r_pix;
    logic [plb_pkg::PIX_W-1:0]  n_pix;
    logic [plb_pkg::PIX_W-1:0]  cmap_addr;
    logic [plb_pkg::ADDR_W-1:0] blend_addr;

    // Each table is written at the stage that reads it, so writes and reads
    // keep item order without any bypass.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_ctl0.vld && i_ctl0.wr_trans) begin
                r_trans[i_ctl0.addr[plb_pkg::PIX_W-1:0]] <= i_ctl0.data;
            end
            r_t1 <= r_trans[i_src];
        end
    end

    assign cmap_addr = i_ctl1.use_trans ? r_t1 : r_src1;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_ctl1.vld && i_ctl1.wr_cmap) begin
                r_cmap[i_ctl1.addr[plb_pkg::PIX_W-1:0]] <= i_ctl1.data;
            end
            r_c2 <= r_cmap[cmap_addr];
        end
    end

    assign blend_addr = {r_dst2, r_c2};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_ctl2.vld && i_ctl2.wr_blend) begin
                r_blend[i_ctl2.addr] <= i_ctl2.data;
            end
            r_b3 <= r_blend[blend_addr];
        end
    end

    always_comb begin
        if (!i_en3) begin
            n_pix = r_dst3;
        end else begin
            unique case (i_ctl3.path)
                plb_pkg::PATH_MAP:   n_pix = r_c3;
                plb_pkg::PATH_BLEND: n_pix = r_b3;
                default:             n_pix = r_src3;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_src1 <= i_src;
            r_dst1 <= i_dst;
            r_src2 <= r_src1;
            r_dst2 <= r_dst1;
            r_c3   <= r_c2;
            r_src3 <= r_src2;
            r_dst3 <= r_dst2;
            r_pix  <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

>>> sv/plb_back.sv
// Back end: lookup pipeline control, lane datapaths and the output register.
module plb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_head_vld,
    input  plb_pkg::t_item               i_head,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output plb_pkg::t_pix_vec            o_pix,
    output logic [plb_pkg::LANE_MAX-1:0] o_lane_enable
);

    plb_pkg::t_ctl               ctl0;
    plb_pkg::t_ctl               r_ctl1, r_ctl2, r_ctl3;
    logic                        r_out_vld;
    logic [plb_pkg::LANE_MAX-1:0] r_out_en;
    logic                        adv;

    // The whole pipe moves together; only a held result freezes it.
    assign adv   = !(r_out_vld && i_stall);
    assign o_pop = adv && i_head_vld;

    always_comb begin
        ctl0     = i_head.ctl;
        ctl0.vld = i_head_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1    <= '0;
            r_ctl2    <= '0;
            r_ctl3    <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_ctl1    <= ctl0;
            r_ctl2    <= r_ctl1;
            r_ctl3    <= r_ctl2;
            r_out_vld <= r_ctl3.vld && r_ctl3.is_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_en <= r_ctl3.en;
        end
    end

    for (genvar l = 0; l < plb_pkg::LANE_MAX; l++) begin : g_lane
        if (l < plb_pkg::LANES) begin : g_on
            plb_lane u_lane (
                .i_clk  (i_clk),
                .i_adv  (adv),
                .i_ctl0 (ctl0),
                .i_ctl1 (r_ctl1),
                .i_ctl2 (r_ctl2),
                .i_ctl3 (r_ctl3),
                .i_src  (i_head.src[l]),
                .i_dst  (i_head.dst[l]),
                .i_en3  (r_ctl3.en[l]),
                .o_pix  (o_pix[l])
            );
        end else begin : g_off
            // lane not built: screen pixel passes through at pipe latency
            logic [plb_pkg::PIX_W-1:0] r_dly [plb_pkg::DLY_STAGES];
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dly[0] <= i_head.dst[l];
                    for (int s = 1; s < plb_pkg::DLY_STAGES; s++) begin
                        r_dly[s] <= r_dly[s-1];
                    end
                end
            end
            assign o_pix[l] = r_dly[plb_pkg::DLY_STAGES-1];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_lane_enable = r_out_en;

    a_pix_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_ctl3.vld && r_ctl3.is_pix) |=> r_out_vld)
        else $error("pixel item in last stage did not produce a result");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !(r_ctl3.vld && r_ctl3.is_pix)) |=> !r_out_vld)
        else $error("result produced without a pixel item");

    a_frozen_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_ctl1) && $stable(r_ctl2) && $stable(r_ctl3)))
        else $error("pipeline moved while the result was held");

    a_no_pop_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |-> !o_pop)
        else $error("queue popped while the pipeline was frozen");

endmodule

>>> sv/palette_lut_blend_lanes_top.sv
// Top level of the four-lane palette lookup and translucency blend block.
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_stall     i_kind, i_src_pixel_*, i_dst_pixel_*,
//                                             i_lane_enable, i_table_addr, i_table_data
//  output    out        o_valid / i_stall     o_out_pixel_*, o_out_lane_enable
//  config    in         i_cfg_we              i_cfg_data (draw mode)
//
// One item per cycle sustained while i_stall is low; a pixel result reaches
// o_valid through the queue, r_ctl1, r_ctl2, r_ctl3 and r_out_vld. The rate is
// set by one read per table per lane per cycle: each lane holds its own
// translation, colormap and 64K blend table. Reset clears the queue and
// pipeline control; tables hold no reset value. A held result freezes the
// lookup pipe; the four-entry queue keeps taking input until it fills, then o_stall rises.
module palette_lut_blend_lanes_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [plb_pkg::MODE_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [plb_pkg::KIND_W-1:0]   i_kind,
    input  logic [plb_pkg::PIX_W-1:0]    i_src_pixel_0,
    input  logic [plb_pkg::PIX_W-1:0]    i_src_pixel_1,
    input  logic [plb_pkg::PIX_W-1:0]    i_src_pixel_2,
    input  logic [plb_pkg::PIX_W-1:0]    i_src_pixel_3,
    input  logic [plb_pkg::PIX_W-1:0]    i_dst_pixel_0,
    input  logic [plb_pkg::PIX_W-1:0]    i_dst_pixel_1,
    input  logic [plb_pkg::PIX_W-1:0]    i_dst_pixel_2,
    input  logic [plb_pkg::PIX_W-1:0]    i_dst_pixel_3,
    input  logic [plb_pkg::LANE_MAX-1:0] i_lane_enable,
    input  logic [plb_pkg::ADDR_W-1:0]   i_table_addr,
    input  logic [plb_pkg::PIX_W-1:0]    i_table_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [plb_pkg::PIX_W-1:0]    o_out_pixel_0,
    output logic [plb_pkg::PIX_W-1:0]    o_out_pixel_1,
    output logic [plb_pkg::PIX_W-1:0]    o_out_pixel_2,
    output logic [plb_pkg::PIX_W-1:0]    o_out_pixel_3,
    output logic [plb_pkg::LANE_MAX-1:0] o_out_lane_enable
);

    plb_pkg::t_pix_vec src;
    plb_pkg::t_pix_vec dst;
    plb_pkg::t_pix_vec pix;
    plb_pkg::t_item    item;
    plb_pkg::t_item    head;
    logic              full;
    logic              head_vld;
    logic              pop;

    assign src = {i_src_pixel_3, i_src_pixel_2, i_src_pixel_1, i_src_pixel_0};
    assign dst = {i_dst_pixel_3, i_dst_pixel_2, i_dst_pixel_1, i_dst_pixel_0};

    plb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_src         (src),
        .i_dst         (dst),
        .i_lane_enable (i_lane_enable),
        .i_table_addr  (i_table_addr),
        .i_table_data  (i_table_data),
        .o_item        (item)
    );

    plb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid),
        .i_item     (item),
        .o_full     (full),
        .i_pop      (pop),
        .o_head_vld (head_vld),
        .o_head     (head)
    );

    plb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_vld    (head_vld),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_pix         (pix),
        .o_lane_enable (o_out_lane_enable)
    );

    assign o_stall       = full;
    assign o_out_pixel_0 = pix[0];
    assign o_out_pixel_1 = pix[1];
    assign o_out_pixel_2 = pix[2];
    assign o_out_pixel_3 = pix[3];

endmodule
